/* hdl/pwc_pkg.sv */
// ----------------------------------------------------------------------------
// Particle wall collision package
// Shared widths, register indexes, operation codes and payload types.
// ----------------------------------------------------------------------------
`default_nettype none
package pwc_pkg;

  localparam int MaxWalls = 16;
  localparam int FracBits = 4;
  localparam int SlotW = 4;
  localparam int StageCount = 2 * MaxWalls;
  localparam int PosW = 20;

  typedef enum logic {OP_LOAD = 1'b0, OP_MOVE = 1'b1} op_t;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_GAIN = 3'd1;
  localparam logic [2:0] REG_GRAVITY = 3'd2;
  localparam logic [2:0] REG_WIDTH = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;
  localparam logic [2:0] REG_WALLS = 3'd5;

  typedef struct packed {
    logic [0:0] op;
    logic [3:0] wall_slot;
    logic [15:0] wall_left;
    logic [15:0] wall_top;
    logic [15:0] wall_width;
    logic [15:0] wall_height;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } in_word_t;

  typedef struct packed {
    logic [15:0] new_pos_x;
    logic [15:0] new_pos_y;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
  } out_word_t;

  typedef struct packed {
    logic [2:0] index;
    logic [15:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
  } wall_t;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
  } part_t;

endpackage
`default_nettype wire

/* hdl/pwc_stream_if.sv */
// ----------------------------------------------------------------------------
// Particle wall collision channels
// Valid/ready channel interfaces for input, output and configuration words.
// ----------------------------------------------------------------------------
`default_nettype none
interface pwc_in_if;
  logic valid;
  logic ready;
  pwc_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pwc_out_if;
  logic valid;
  logic ready;
  pwc_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pwc_cfg_if;
  logic valid;
  logic ready;
  pwc_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/particle_wall_collision_step.sv */
// ----------------------------------------------------------------------------
// Particle wall collision step
// Moves one particle per word against a table of wall rectangles.
// ----------------------------------------------------------------------------
// channel  | dir | word
// in_ch    | in  | op, wall fields, position, velocity
// out_ch   | out | new position and velocity, one per move word
// cfg_ch   | in  | register index and data
// One move word enters per cycle while the output is not stalled. A move
// passes one pipeline stage for each wall and axis, one entry stage and two
// result stages. Loads write the wall table at entry and give no word;
// a load waits until no earlier move is left in the wall stages.
// Reset is synchronous, clears valid bits and sets registers to defaults;
// the wall table is not cleared. Output stalls freeze the whole pipeline.
`default_nettype none
module particle_wall_collision_step (
  input wire logic clk,
  input wire logic rst,
  pwc_in_if.sink in_ch,
  pwc_out_if.source out_ch,
  pwc_cfg_if.sink cfg_ch
);
  import pwc_pkg::*;

  logic [11:0] radius;
  logic [8:0] gain;
  logic signed [9:0] gravity;
  logic [15:0] arena_w;
  logic [15:0] arena_h;
  logic [4:0] walls_n;

  wall_t wall_mem [MaxWalls];
  logic [StageCount:0] sv;
  part_t sp [StageCount+1];
  logic [1:0] rv;
  part_t rp;
  out_word_t ow;
  logic adv;
  logic walls_busy;
  logic signed [16:0] vy_g;
  logic signed [15:0] vy_sat;
  logic [5:0] n_eff;

  assign adv = !out_ch.valid || out_ch.ready;
  assign walls_busy = |sv[StageCount-1:0];
  assign in_ch.ready = adv && !(in_ch.data.op == OP_LOAD && walls_busy);
  assign cfg_ch.ready = 1'b1;
  assign n_eff = (walls_n > 5'(MaxWalls)) ? 6'(MaxWalls) : {1'b0, walls_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 12'd160;
      gain <= 9'd256;
      gravity <= '0;
      arena_w <= 16'd30720;
      arena_h <= 16'd17280;
      walls_n <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        REG_RADIUS: radius <= cfg_ch.data.data[11:0];
        REG_GAIN: gain <= cfg_ch.data.data[8:0];
        REG_GRAVITY: gravity <= cfg_ch.data.data[9:0];
        REG_WIDTH: arena_w <= cfg_ch.data.data;
        REG_HEIGHT: arena_h <= cfg_ch.data.data;
        REG_WALLS: walls_n <= cfg_ch.data.data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.data.op == OP_LOAD) begin
      wall_mem[in_ch.data.wall_slot] <= '{in_ch.data.wall_left, in_ch.data.wall_top,
                                          in_ch.data.wall_width, in_ch.data.wall_height};
    end
  end

  assign vy_g = 17'(in_ch.data.vel_y) + 17'(gravity);
  assign vy_sat = (vy_g > 17'sd32767) ? 16'sh7fff :
                  (vy_g < -17'sd32768) ? 16'sh8000 : vy_g[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= in_ch.valid && in_ch.data.op == OP_MOVE;
    end
    if (adv) begin
      sp[0].x <= PosW'($signed({1'b0, in_ch.data.pos_x})) + PosW'(in_ch.data.vel_x);
      sp[0].y <= PosW'({1'b0, in_ch.data.pos_y});
      sp[0].vx <= in_ch.data.vel_x;
      sp[0].vy <= vy_sat;
    end
  end

  for (genvar s = 0; s < StageCount; s++) begin : g_stage
    localparam int W = s % MaxWalls;
    localparam bit YAX = (s >= MaxWalls);
    wall_t w;
    part_t pi, po;
    logic signed [PosW-1:0] p, q, pn, l, t, wl, th, side, r2;
    logic signed [PosW-1:0] vin;
    logic hit, pos_side;
    logic signed [PosW+1:0] cb, cw;
    logic [15:0] mag;
    logic [25:0] prod;
    logic [17:0] smag;
    logic signed [15:0] vout;

    assign w = wall_mem[W];
    assign pi = sp[s];
    assign p = YAX ? pi.y : pi.x;
    assign q = YAX ? pi.x : pi.y;
    assign l = YAX ? PosW'({1'b0, w.top}) : PosW'({1'b0, w.left});
    assign wl = YAX ? PosW'({1'b0, w.height}) : PosW'({1'b0, w.width});
    assign t = YAX ? PosW'({1'b0, w.left}) : PosW'({1'b0, w.top});
    assign th = YAX ? PosW'({1'b0, w.width}) : PosW'({1'b0, w.height});
    assign r2 = PosW'({radius, 1'b0});
    assign side = r2;
    assign hit = (6'(W) < n_eff)
        && ((p > l ? p : l) < ((p + side) < (l + wl) ? (p + side) : (l + wl)))
        && ((q > t ? q : t) < ((q + side) < (t + th) ? (q + side) : (t + th)));
    assign cb = ((PosW+2)'(p) <<< 1) + (PosW+2)'(r2);
    assign cw = ((PosW+2)'(l) <<< 1) + (PosW+2)'(wl);
    assign pos_side = cb > cw;
    assign vin = YAX ? PosW'(pi.vy) : PosW'(pi.vx);
    assign mag = vin[PosW-1] ? 16'(-vin) : 16'(vin);
    assign prod = 26'(mag) * 26'(gain);
    assign smag = prod[25:8] > 18'd32767 ? 18'd32768 : prod[25:8];
    assign vout = pos_side ? ((smag > 18'd32767) ? 16'sh7fff : 16'(smag))
                           : 16'(-smag);
    assign pn = pos_side ? l + wl : l - r2;

    always_comb begin
      po = pi;
      if (hit) begin
        if (YAX) begin
          po.y = pn;
          po.vy = vout;
        end else begin
          po.x = pn;
          po.vx = vout;
        end
      end
      if (!YAX && s == MaxWalls - 1) begin
        po.y = po.y + PosW'(po.vy);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[s+1] <= 1'b0;
      end else if (adv) begin
        sv[s+1] <= sv[s];
      end
      if (adv) begin
        sp[s+1] <= po;
      end
    end
  end

  function automatic logic [15:0] clamp(input logic signed [PosW-1:0] c,
                                        input logic [15:0] b);
    logic signed [PosW-1:0] bb;
    bb = PosW'({1'b0, b});
    if (c < 0) begin
      return '0;
    end else if (c > bb) begin
      return (b < 16'(1 << FracBits)) ? 16'd0 : b - 16'(1 << FracBits);
    end
    return c[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= '0;
    end else if (adv) begin
      rv <= {rv[0], sv[StageCount]};
    end
    if (adv) begin
      rp <= sp[StageCount];
      ow <= '{clamp(rp.x, arena_w), clamp(rp.y, arena_h), rp.vx, rp.vy};
    end
  end

  assign out_ch.valid = rv[1];
  assign out_ch.data = ow;
endmodule
`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Particle wall collision step testbench
// Loads wall tables and streams particles through the step under several
// register settings, with random gaps on both channels and one long output
// hold. Every result word is checked field by field against a predicted
// particle update.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import pwc_pkg::*;

  localparam int Latency = 2 * MaxWalls + 3;
  localparam int SettleCycles = Latency + 8;
  localparam int WatchdogLimit = 4000;
  localparam int LongHold = 300;

  class particle_scoreboard;
    longint radius, gain, gravity, arena_w, arena_h, walls_used;
    longint wl[MaxWalls], wt[MaxWalls], ww[MaxWalls], wh[MaxWalls];
    out_word_t expected_words[$];
    int mismatches;

    function new();
      radius = 160;
      gain = 256;
      gravity = 0;
      arena_w = 30720;
      arena_h = 17280;
      walls_used = 0;
      mismatches = 0;
      foreach (wl[i]) begin
        wl[i] = 0;
        wt[i] = 0;
        ww[i] = 0;
        wh[i] = 0;
      end
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint scaled(longint v, bit positive);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = mag * gain / 256;
      return sat16(positive ? mag : -mag);
    endfunction

    function bit overlaps(longint x, longint y, int i);
      longint side;
      bit ox, oy;
      side = 2 * radius;
      ox = ((x > wl[i]) ? x : wl[i]) < ((x + side < wl[i] + ww[i]) ? x + side : wl[i] + ww[i]);
      oy = ((y > wt[i]) ? y : wt[i]) < ((y + side < wt[i] + wh[i]) ? y + side : wt[i] + wh[i]);
      return ox && oy;
    endfunction

    function longint clamp(longint c, longint bound);
      if (c < 0) c = 0;
      if (c > bound) begin
        c = bound - (64'sd1 << FracBits);
        if (c < 0) c = 0;
      end
      return c;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] value);
      case (idx)
        REG_RADIUS: radius = value[11:0];
        REG_GAIN: gain = value[8:0];
        REG_GRAVITY: gravity = longint'($signed(value[9:0]));
        REG_WIDTH: arena_w = value;
        REG_HEIGHT: arena_h = value;
        REG_WALLS: walls_used = value[4:0];
        default: ;
      endcase
    endfunction

    function void note_input(in_word_t w);
      longint x, y, vx, vy, n;
      out_word_t r;
      if (op_t'(w.op) == OP_LOAD) begin
        wl[w.wall_slot] = w.wall_left;
        wt[w.wall_slot] = w.wall_top;
        ww[w.wall_slot] = w.wall_width;
        wh[w.wall_slot] = w.wall_height;
        return;
      end
      x = w.pos_x;
      y = w.pos_y;
      vx = w.vel_x;
      vy = w.vel_y;
      n = (walls_used < MaxWalls) ? walls_used : MaxWalls;
      vy = sat16(vy + gravity);
      x = x + vx;
      for (int i = 0; i < n; i++) begin
        if (overlaps(x, y, i)) begin
          if (2 * (x + radius) > 2 * wl[i] + ww[i]) begin
            vx = scaled(vx, 1'b1);
            x = wl[i] + ww[i];
          end else begin
            vx = scaled(vx, 1'b0);
            x = wl[i] - 2 * radius;
          end
        end
      end
      y = y + vy;
      for (int i = 0; i < n; i++) begin
        if (overlaps(x, y, i)) begin
          if (2 * (y + radius) > 2 * wt[i] + wh[i]) begin
            vy = scaled(vy, 1'b1);
            y = wt[i] + wh[i];
          end else begin
            vy = scaled(vy, 1'b0);
            y = wt[i] - 2 * radius;
          end
        end
      end
      r.new_pos_x = 16'(clamp(x, arena_w));
      r.new_pos_y = 16'(clamp(y, arena_h));
      r.new_vel_x = 16'(vx);
      r.new_vel_y = 16'(vy);
      expected_words = {expected_words, r};
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", got);
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.new_pos_x !== exp_w.new_pos_x || got.new_pos_y !== exp_w.new_pos_y ||
          got.new_vel_x !== exp_w.new_vel_x || got.new_vel_y !== exp_w.new_vel_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected x=%0d y=%0d vx=%0d vy=%0d, got x=%0d y=%0d vx=%0d vy=%0d",
                   exp_w.new_pos_x, exp_w.new_pos_y, exp_w.new_vel_x, exp_w.new_vel_y,
                   got.new_pos_x, got.new_pos_y, got.new_vel_x, got.new_vel_y);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  pwc_in_if in_if();
  pwc_out_if out_if();
  pwc_cfg_if cfg_if();

  particle_scoreboard sb;
  int rx_gap_max;
  bit hold_request;
  int idle_cycles;

  particle_wall_collision_step dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_if.sink),
    .out_ch(out_if.source),
    .cfg_ch(cfg_if.sink)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    sb = new();
    rx_gap_max = 0;
    hold_request = 1'b0;
    idle_cycles = 0;
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result receiver with random stalls and one long hold on request.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = (rx_gap_max > 0) ? $urandom_range(rx_gap_max, 0) : 0;
      if (hold_request) begin
        gap = LongHold;
        hold_request = 1'b0;
      end
      if (gap > 0) begin
        @(negedge clk) out_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      sb.check_result(out_if.data);
    end
  end

  task automatic send_word(in_word_t w, int gap);
    if (gap > 0) begin
      @(negedge clk) in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data <= w;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(w);
  endtask

  task automatic end_burst();
    @(negedge clk) in_if.valid <= 1'b0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, data: value};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk) cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_words.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_regs(int r, int g, int grav, int aw, int ah, int nw);
    write_reg(REG_RADIUS, 16'(r));
    write_reg(REG_GAIN, 16'(g));
    write_reg(REG_GRAVITY, 16'(grav));
    write_reg(REG_WIDTH, 16'(aw));
    write_reg(REG_HEIGHT, 16'(ah));
    write_reg(REG_WALLS, 16'(nw));
  endtask

  function automatic in_word_t load_word(int slot, bit full_range);
    in_word_t w;
    w = '0;
    w.op = OP_LOAD;
    w.wall_slot = 4'(slot);
    if (full_range) begin
      w.wall_left = 16'($urandom);
      w.wall_top = 16'($urandom);
      w.wall_width = 16'($urandom);
      w.wall_height = 16'($urandom);
    end else begin
      w.wall_left = 16'($urandom_range(12000, 0));
      w.wall_top = 16'($urandom_range(8000, 0));
      w.wall_width = ($urandom_range(9, 0) == 0) ? 16'd0 : 16'($urandom_range(1500, 1));
      w.wall_height = ($urandom_range(9, 0) == 0) ? 16'd0 : 16'($urandom_range(1500, 1));
    end
    return w;
  endfunction

  function automatic in_word_t move_word(in_word_t w_in, int nw);
    in_word_t w;
    int k;
    w = w_in;
    w.op = OP_MOVE;
    if ($urandom_range(9, 0) == 0) begin
      w.pos_x = 16'($urandom);
      w.pos_y = 16'($urandom);
      w.vel_x = 16'($urandom);
      w.vel_y = 16'($urandom);
    end else begin
      k = (nw > 0) ? $urandom_range(nw - 1, 0) : $urandom_range(MaxWalls - 1, 0);
      w.pos_x = 16'(sb.wl[k] + $urandom_range(1200, 0) - 700);
      w.pos_y = 16'(sb.wt[k] + $urandom_range(1200, 0) - 700);
      w.vel_x = 16'(int'($urandom_range(800, 0)) - 400);
      w.vel_y = 16'(int'($urandom_range(800, 0)) - 400);
    end
    return w;
  endfunction

  initial begin
    in_word_t w;
    int tx_gap_max, nw, walls_cap;
    int radius_set[6] = '{160, 0, 4095, 40, 160, 300};
    int gain_set[6] = '{256, 0, 511, 128, 200, 256};
    int grav_set[6] = '{0, -256, 256, -512, 511, 17};
    int aw_set[6] = '{30720, 16, 65535, 0, 30720, 4000};
    int ah_set[6] = '{17280, 16, 65535, 0, 17280, 3000};
    int nw_set[6] = '{16, 31, 16, 8, 3, 0};

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: fill the whole wall table, then moves at the field extremes.
    rx_gap_max = 3;
    for (int s = 0; s < MaxWalls; s++) begin
      w = load_word(s, s == 15);
      if (s == 0) begin
        w.wall_left = 16'd0;
        w.wall_top = 16'd0;
        w.wall_width = 16'd0;
        w.wall_height = 16'd0;
      end
      if (s == 1) begin
        w.wall_left = 16'd2000;
        w.wall_top = 16'd2000;
        w.wall_width = 16'd640;
        w.wall_height = 16'd640;
      end
      send_word(w, s % 3);
    end
    end_burst();
    drain();
    write_reg(REG_WALLS, 16'd16);
    w = '0;
    w.op = OP_MOVE;
    send_word(w, 0);
    w.pos_x = 16'hFFFF; w.pos_y = 16'hFFFF; w.vel_x = 16'sh7FFF; w.vel_y = 16'sh7FFF;
    send_word(w, 0);
    w.pos_x = 16'd0; w.pos_y = 16'd0; w.vel_x = -16'sh8000; w.vel_y = -16'sh8000;
    send_word(w, 1);
    // Center exactly on the wall center, so the tie goes left.
    w.pos_x = 16'd2160; w.pos_y = 16'd2160; w.vel_x = 16'sd0; w.vel_y = 16'sd0;
    send_word(w, 0);
    // Touching edges only, no overlap.
    w.pos_x = 16'd1680; w.pos_y = 16'd2100; w.vel_x = 16'sd0; w.vel_y = 16'sd0;
    send_word(w, 0);
    w.pos_x = 16'd1670; w.vel_x = 16'sd20;
    send_word(w, 2);
    w.pos_x = 16'd2650; w.pos_y = 16'd1700; w.vel_x = -16'sd30; w.vel_y = 16'sd200;
    send_word(w, 0);
    w.pos_x = 16'd40000; w.pos_y = 16'd30000; w.vel_x = 16'sd5; w.vel_y = -16'sd5;
    send_word(w, 0);
    end_burst();
    drain();

    for (int p = 0; p < 6; p++) begin
      set_regs(radius_set[p], gain_set[p], grav_set[p], aw_set[p], ah_set[p], nw_set[p]);
      nw = nw_set[p];
      walls_cap = (nw < MaxWalls) ? nw : MaxWalls;
      tx_gap_max = (p % 2 == 0) ? 14 : 0;
      rx_gap_max = (p == 3) ? 0 : 14;
      for (int i = 0; i < 210; i++) begin
        if (p == 2 && i == 20) hold_request = 1'b1;
        if ($urandom_range(9, 0) == 0)
          w = load_word($urandom_range(MaxWalls - 1, 0), $urandom_range(3, 0) == 0);
        else
          w = move_word(load_word(0, 1'b1), walls_cap);
        w.wall_slot = ($urandom_range(9, 0) == 0) ? 4'($urandom) : w.wall_slot;
        send_word(w, (tx_gap_max > 0 && $urandom_range(3, 0) != 0) ?
                  $urandom_range(tx_gap_max, 0) : 0);
      end
      end_burst();
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_words.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
